### rtl/core/qmd_pkg.sv
package qmd_pkg;

   localparam int CONTEXT_BITS = 13;
   localparam int CTX_COUNT    = 1 << CONTEXT_BITS;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_DECODE = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic [6:0] QE_LAST_STATE = 7'd112;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  compressed_byte;
      logic [23:0] byte_count;
      logic [12:0] context_index;
   } req_type;

   typedef struct packed {
      logic       decoded_bit;
      logic       bit_valid;
      logic       exhausted;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    is_push;
      logic    is_start;
      logic    is_decode;
      logic    is_clear;
   } cmd_type;

   typedef struct packed {
      logic [15:0] qe;
      logic [6:0]  nlps;
      logic [6:0]  nmps;
      logic        sw;
   } qe_row_type;

   function automatic qe_row_type qe_lookup(input logic [6:0] s);
      qe_row_type r;
      unique case (s)
         7'd0:   r = {16'h5A1D, 7'd1, 7'd1, 1'b1};
         7'd1:   r = {16'h2586, 7'd14, 7'd2, 1'b0};
         7'd2:   r = {16'h1114, 7'd16, 7'd3, 1'b0};
         7'd3:   r = {16'h080B, 7'd18, 7'd4, 1'b0};
         7'd4:   r = {16'h03D8, 7'd20, 7'd5, 1'b0};
         7'd5:   r = {16'h01DA, 7'd23, 7'd6, 1'b0};
         7'd6:   r = {16'h00E5, 7'd25, 7'd7, 1'b0};
         7'd7:   r = {16'h006F, 7'd28, 7'd8, 1'b0};
         7'd8:   r = {16'h0036, 7'd30, 7'd9, 1'b0};
         7'd9:   r = {16'h001A, 7'd33, 7'd10, 1'b0};
         7'd10:  r = {16'h000D, 7'd35, 7'd11, 1'b0};
         7'd11:  r = {16'h0006, 7'd9, 7'd12, 1'b0};
         7'd12:  r = {16'h0003, 7'd10, 7'd13, 1'b0};
         7'd13:  r = {16'h0001, 7'd12, 7'd13, 1'b0};
         7'd14:  r = {16'h5A7F, 7'd15, 7'd15, 1'b1};
         7'd15:  r = {16'h3F25, 7'd36, 7'd16, 1'b0};
         7'd16:  r = {16'h2CF2, 7'd38, 7'd17, 1'b0};
         7'd17:  r = {16'h207C, 7'd39, 7'd18, 1'b0};
         7'd18:  r = {16'h17B9, 7'd40, 7'd19, 1'b0};
         7'd19:  r = {16'h1182, 7'd42, 7'd20, 1'b0};
         7'd20:  r = {16'h0CEF, 7'd43, 7'd21, 1'b0};
         7'd21:  r = {16'h09A1, 7'd45, 7'd22, 1'b0};
         7'd22:  r = {16'h072F, 7'd46, 7'd23, 1'b0};
         7'd23:  r = {16'h055C, 7'd48, 7'd24, 1'b0};
         7'd24:  r = {16'h0406, 7'd49, 7'd25, 1'b0};
         7'd25:  r = {16'h0303, 7'd51, 7'd26, 1'b0};
         7'd26:  r = {16'h0240, 7'd52, 7'd27, 1'b0};
         7'd27:  r = {16'h01B1, 7'd54, 7'd28, 1'b0};
         7'd28:  r = {16'h0144, 7'd56, 7'd29, 1'b0};
         7'd29:  r = {16'h00F5, 7'd57, 7'd30, 1'b0};
         7'd30:  r = {16'h00B7, 7'd59, 7'd31, 1'b0};
         7'd31:  r = {16'h008A, 7'd60, 7'd32, 1'b0};
         7'd32:  r = {16'h0068, 7'd62, 7'd33, 1'b0};
         7'd33:  r = {16'h004E, 7'd63, 7'd34, 1'b0};
         7'd34:  r = {16'h003B, 7'd32, 7'd35, 1'b0};
         7'd35:  r = {16'h002C, 7'd33, 7'd9, 1'b0};
         7'd36:  r = {16'h5AE1, 7'd37, 7'd37, 1'b1};
         7'd37:  r = {16'h484C, 7'd64, 7'd38, 1'b0};
         7'd38:  r = {16'h3A0D, 7'd65, 7'd39, 1'b0};
         7'd39:  r = {16'h2EF1, 7'd67, 7'd40, 1'b0};
         7'd40:  r = {16'h261F, 7'd68, 7'd41, 1'b0};
         7'd41:  r = {16'h1F33, 7'd69, 7'd42, 1'b0};
         7'd42:  r = {16'h19A8, 7'd70, 7'd43, 1'b0};
         7'd43:  r = {16'h1518, 7'd72, 7'd44, 1'b0};
         7'd44:  r = {16'h1177, 7'd73, 7'd45, 1'b0};
         7'd45:  r = {16'h0E74, 7'd74, 7'd46, 1'b0};
         7'd46:  r = {16'h0BFB, 7'd75, 7'd47, 1'b0};
         7'd47:  r = {16'h09F8, 7'd77, 7'd48, 1'b0};
         7'd48:  r = {16'h0861, 7'd78, 7'd49, 1'b0};
         7'd49:  r = {16'h0706, 7'd79, 7'd50, 1'b0};
         7'd50:  r = {16'h05CD, 7'd48, 7'd51, 1'b0};
         7'd51:  r = {16'h04DE, 7'd50, 7'd52, 1'b0};
         7'd52:  r = {16'h040F, 7'd50, 7'd53, 1'b0};
         7'd53:  r = {16'h0363, 7'd51, 7'd54, 1'b0};
         7'd54:  r = {16'h02D4, 7'd52, 7'd55, 1'b0};
         7'd55:  r = {16'h025C, 7'd53, 7'd56, 1'b0};
         7'd56:  r = {16'h01F8, 7'd54, 7'd57, 1'b0};
         7'd57:  r = {16'h01A4, 7'd55, 7'd58, 1'b0};
         7'd58:  r = {16'h0160, 7'd56, 7'd59, 1'b0};
         7'd59:  r = {16'h0125, 7'd57, 7'd60, 1'b0};
         7'd60:  r = {16'h00F6, 7'd58, 7'd61, 1'b0};
         7'd61:  r = {16'h00CB, 7'd59, 7'd62, 1'b0};
         7'd62:  r = {16'h00AB, 7'd61, 7'd63, 1'b0};
         7'd63:  r = {16'h008F, 7'd61, 7'd32, 1'b0};
         7'd64:  r = {16'h5B12, 7'd65, 7'd65, 1'b1};
         7'd65:  r = {16'h4D04, 7'd80, 7'd66, 1'b0};
         7'd66:  r = {16'h412C, 7'd81, 7'd67, 1'b0};
         7'd67:  r = {16'h37D8, 7'd82, 7'd68, 1'b0};
         7'd68:  r = {16'h2FE8, 7'd83, 7'd69, 1'b0};
         7'd69:  r = {16'h293C, 7'd84, 7'd70, 1'b0};
         7'd70:  r = {16'h2379, 7'd86, 7'd71, 1'b0};
         7'd71:  r = {16'h1EDF, 7'd87, 7'd72, 1'b0};
         7'd72:  r = {16'h1AA9, 7'd87, 7'd73, 1'b0};
         7'd73:  r = {16'h174E, 7'd72, 7'd74, 1'b0};
         7'd74:  r = {16'h1424, 7'd72, 7'd75, 1'b0};
         7'd75:  r = {16'h119C, 7'd74, 7'd76, 1'b0};
         7'd76:  r = {16'h0F6B, 7'd74, 7'd77, 1'b0};
         7'd77:  r = {16'h0D51, 7'd75, 7'd78, 1'b0};
         7'd78:  r = {16'h0BB6, 7'd77, 7'd79, 1'b0};
         7'd79:  r = {16'h0A40, 7'd77, 7'd48, 1'b0};
         7'd80:  r = {16'h5832, 7'd80, 7'd81, 1'b1};
         7'd81:  r = {16'h4D1C, 7'd88, 7'd82, 1'b0};
         7'd82:  r = {16'h438E, 7'd89, 7'd83, 1'b0};
         7'd83:  r = {16'h3BDD, 7'd90, 7'd84, 1'b0};
         7'd84:  r = {16'h34EE, 7'd91, 7'd85, 1'b0};
         7'd85:  r = {16'h2EAE, 7'd92, 7'd86, 1'b0};
         7'd86:  r = {16'h299A, 7'd93, 7'd87, 1'b0};
         7'd87:  r = {16'h2516, 7'd86, 7'd71, 1'b0};
         7'd88:  r = {16'h5570, 7'd88, 7'd89, 1'b1};
         7'd89:  r = {16'h4CA9, 7'd95, 7'd90, 1'b0};
         7'd90:  r = {16'h44D9, 7'd96, 7'd91, 1'b0};
         7'd91:  r = {16'h3E22, 7'd97, 7'd92, 1'b0};
         7'd92:  r = {16'h3824, 7'd99, 7'd93, 1'b0};
         7'd93:  r = {16'h32B4, 7'd99, 7'd94, 1'b0};
         7'd94:  r = {16'h2E17, 7'd93, 7'd86, 1'b0};
         7'd95:  r = {16'h56A8, 7'd95, 7'd96, 1'b1};
         7'd96:  r = {16'h4F46, 7'd101, 7'd97, 1'b0};
         7'd97:  r = {16'h47E5, 7'd102, 7'd98, 1'b0};
         7'd98:  r = {16'h41CF, 7'd103, 7'd99, 1'b0};
         7'd99:  r = {16'h3C3D, 7'd104, 7'd100, 1'b0};
         7'd100: r = {16'h375E, 7'd99, 7'd93, 1'b0};
         7'd101: r = {16'h5231, 7'd105, 7'd102, 1'b0};
         7'd102: r = {16'h4C0F, 7'd106, 7'd103, 1'b0};
         7'd103: r = {16'h4639, 7'd107, 7'd104, 1'b0};
         7'd104: r = {16'h415E, 7'd103, 7'd99, 1'b0};
         7'd105: r = {16'h5627, 7'd105, 7'd106, 1'b1};
         7'd106: r = {16'h50E7, 7'd108, 7'd107, 1'b0};
         7'd107: r = {16'h4B85, 7'd109, 7'd103, 1'b0};
         7'd108: r = {16'h5597, 7'd110, 7'd109, 1'b0};
         7'd109: r = {16'h504F, 7'd111, 7'd107, 1'b0};
         7'd110: r = {16'h5A10, 7'd110, 7'd111, 1'b1};
         7'd111: r = {16'h5522, 7'd112, 7'd109, 1'b0};
         default: r = {16'h59EB, 7'd112, 7'd111, 1'b1};
      endcase
      return r;
   endfunction

endpackage

### rtl/core/qmd_front.sv
module qmd_front
   import qmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_take
);

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   cmd_type    cls;

   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ff];

   always_comb begin
      cls.req       = req_data;
      cls.is_push   = (req_data.mode == MODE_PUSH);
      cls.is_start  = (req_data.mode == MODE_START);
      cls.is_decode = (req_data.mode == MODE_DECODE);
      cls.is_clear  = (req_data.mode == MODE_CLEAR);
      wr_in  = push_ok ? !wr_ff : wr_ff;
      rd_in  = cmd_take ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/core/qmd_back.sv
module qmd_back
   import qmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_take,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_DECODE = 3'd3;
   localparam logic [2:0] S_RENORM = 3'd4;

   localparam int QSUM_BITS = QCNT_BITS + 1;

   logic [7:0] ctx_mem [CTX_COUNT];
   logic [7:0] rd_ff;
   logic                    mem_we;
   logic [CONTEXT_BITS-1:0] mem_waddr;
   logic [7:0]              mem_wdata;
   logic [CONTEXT_BITS-1:0] mem_raddr;

   logic [2:0]  state_ff, state_in;
   logic [16:0] a_ff, a_in;
   logic [32:0] c_ff, c_in;
   logic [3:0]  ct_ff, ct_in;
   logic [23:0] bl_ff, bl_in;
   logic        exh_ff, exh_in;
   logic        under_ff, under_in;
   logic        step_ff, step_in;
   logic        clr_rsp_ff, clr_rsp_in;
   logic        bit_ff, bit_in;
   logic [CONTEXT_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [CONTEXT_BITS-1:0] idx_ff, idx_in;
   logic [7:0]  q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] head_ff, head_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        q_we;
   logic [QPTR_BITS-1:0] tail;
   logic [QSUM_BITS-1:0] tail_wide;

   logic        f_go, f_exh, f_under, f_pop;
   logic [23:0] f_bl;
   logic [32:0] f_c;
   logic [7:0]  f_byte;

   qe_row_type  row;
   logic [6:0]  s_cl;
   logic [16:0] a_sub;
   logic [16:0] a_sh;
   logic [3:0]  ct_base;
   logic        mps, lps, adapt;
   logic [6:0]  s_next;
   logic        mps_next;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid && !rsp_valid_ff;
   assign mem_raddr = cmd_data.req.context_index[CONTEXT_BITS-1:0];

   assign tail_wide = QSUM_BITS'(head_ff) + QSUM_BITS'(cnt_ff);
   assign tail = (tail_wide >= QSUM_BITS'(QUEUE_DEPTH))
      ? QPTR_BITS'(tail_wide - QSUM_BITS'(QUEUE_DEPTH)) : QPTR_BITS'(tail_wide);

   // byte fetch into the code register
   always_comb begin
      f_c     = c_ff;
      f_bl    = bl_ff;
      f_exh   = exh_ff;
      f_under = 1'b0;
      f_pop   = 1'b0;
      f_byte  = q_ff[head_ff];
      if (f_go) begin
         if (bl_ff == 24'd0) begin
            f_exh = 1'b1;
         end else begin
            f_bl = bl_ff - 24'd1;
            if (cnt_ff == '0) begin
               f_under = 1'b1;
            end else begin
               f_pop = 1'b1;
               if (f_byte == 8'hFF) begin
                  f_c = c_ff | 33'h0FF00;
               end else begin
                  f_c = c_ff + {17'd0, f_byte, 8'd0};
               end
            end
         end
      end
   end

   always_comb begin
      s_cl     = (rd_ff[6:0] > QE_LAST_STATE) ? QE_LAST_STATE : rd_ff[6:0];
      row      = qe_lookup(s_cl);
      mps      = rd_ff[7];
      a_sub    = a_ff - {1'b0, row.qe};
      lps      = 1'b0;
      adapt    = 1'b1;
      a_sh     = {a_ff[15:0], 1'b0};
      ct_base  = (ct_ff == 4'd0) ? 4'd8 : ct_ff;
      s_next   = row.nmps;
      mps_next = mps;

      state_in     = state_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      ct_in        = ct_ff;
      bl_in        = bl_ff;
      exh_in       = exh_ff;
      under_in     = under_ff;
      step_in      = step_ff;
      clr_rsp_in   = clr_rsp_ff;
      clr_addr_in  = clr_addr_ff;
      bit_in       = bit_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      q_we         = 1'b0;
      f_go         = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = 8'd0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + CONTEXT_BITS'(1);
            if (clr_addr_ff == {CONTEXT_BITS{1'b1}}) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{decoded_bit: 1'b0, bit_valid: 1'b0, exhausted: exh_ff,
                             status: STATUS_OK};
               end
            end
         end
         S_IDLE: begin
            if (cmd_take) begin
               under_in = 1'b0;
               if (cmd_data.is_push) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{decoded_bit: 1'b0, bit_valid: 1'b0, exhausted: exh_ff,
                             status: STATUS_OK};
                  if (cnt_ff == QCNT_BITS'(QUEUE_DEPTH)) begin
                     rsp_in.status = STATUS_OVERFLOW;
                  end else begin
                     q_we   = 1'b1;
                     cnt_in = cnt_ff + QCNT_BITS'(1);
                  end
               end else if (cmd_data.is_start) begin
                  bl_in    = cmd_data.req.byte_count;
                  exh_in   = 1'b0;
                  a_in     = 17'h10000;
                  c_in     = 33'd0;
                  step_in  = 1'b0;
                  state_in = S_START;
               end else if (cmd_data.is_decode) begin
                  idx_in   = mem_raddr;
                  state_in = S_DECODE;
               end else begin
                  clr_addr_in = '0;
                  clr_rsp_in  = 1'b1;
                  state_in    = S_CLEAR;
               end
            end
         end
         S_START: begin
            f_go     = 1'b1;
            c_in     = {f_c[24:0], 8'd0};
            bl_in    = f_bl;
            exh_in   = f_exh;
            under_in = under_ff | f_under;
            step_in  = 1'b1;
            if (step_ff) begin
               ct_in        = 4'd0;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '{decoded_bit: 1'b0, bit_valid: 1'b0, exhausted: f_exh,
                          status: (under_ff | f_under) ? STATUS_UNDERFLOW : STATUS_OK};
            end
         end
         S_DECODE: begin
            a_in   = a_sub;
            bit_in = mps;
            if (c_ff[32:16] < a_sub) begin
               if (a_sub >= 17'h08000) begin
                  adapt = 1'b0;
               end else begin
                  lps = a_sub < {1'b0, row.qe};
               end
            end else begin
               c_in = c_ff - {a_sub, 16'd0};
               lps  = a_sub >= {1'b0, row.qe};
               a_in = {1'b0, row.qe};
            end
            if (lps) begin
               bit_in   = !mps;
               mps_next = mps ^ row.sw;
               s_next   = row.nlps;
            end
            if (adapt) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = {mps_next, s_next};
               state_in  = S_RENORM;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '{decoded_bit: mps, bit_valid: 1'b1, exhausted: exh_ff,
                          status: STATUS_OK};
            end
         end
         S_RENORM: begin
            f_go     = (ct_ff == 4'd0);
            a_in     = a_sh;
            c_in     = {f_c[31:0], 1'b0};
            ct_in    = ct_base - 4'd1;
            bl_in    = f_bl;
            exh_in   = f_exh;
            under_in = under_ff | f_under;
            if (!(a_sh < 17'h08000 && a_sh != 17'd0)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '{decoded_bit: bit_ff, bit_valid: 1'b1, exhausted: f_exh,
                          status: (under_ff | f_under) ? STATUS_UNDERFLOW : STATUS_OK};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (f_pop) begin
         cnt_in  = cnt_ff - QCNT_BITS'(1);
         head_in = (head_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QPTR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ctx_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= ctx_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_ff[tail] <= cmd_data.req.compressed_byte;
      end
      rsp_ff <= rsp_in;
      bit_ff <= bit_in;
      idx_ff <= idx_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         a_ff         <= '0;
         c_ff         <= '0;
         ct_ff        <= '0;
         bl_ff        <= '0;
         exh_ff       <= 1'b0;
         under_ff     <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         c_ff         <= c_in;
         ct_ff        <= ct_in;
         bl_ff        <= bl_in;
         exh_ff       <= exh_in;
         under_ff     <= under_in;
         clr_rsp_ff   <= clr_rsp_in;
         clr_addr_ff  <= clr_addr_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/qm_binary_arithmetic_decoder.sv
// QM-coder binary arithmetic decoder.
// Request queue: req_data beats (mode, byte, budget, context) go in with
// req_push while req_full is low; a two-beat command queue lets requests
// land while the decoder works. Response queue: one rsp_data beat per
// request, in order, shown while rsp_empty is low and taken with rsp_pop.
// Request steps: a push is handled in the idle state; a start segment
// fetches code bytes in the start state; a decode of a bit runs in the
// decode state and, when the context adapts, shifts the interval once per
// cycle through the renormalization loop. Context clear writes all
// 8192 context entries, one context entry per cycle. Throughput: one
// request at a time; the next one is taken the cycle after the previous
// response is popped. After reset the same pass clears the context memory;
// requests are queued during it but not executed until it ends.
// The response register holds one beat; while it waits for rsp_pop the
// decoder stalls, and new requests are held in the command queue until
// it fills and req_full rises.
module qm_binary_arithmetic_decoder
   import qmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;

   qmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   qmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
